// ----- sv/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants, sector codes and stage records for the HSV to RGB
// converter pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_FRAC_BITS     = 6;
  localparam int CHANNEL_FRAC_BITS = 8;

  localparam int HUE_W   = 15;
  localparam int CH_W    = 9;
  localparam int BYTE_W  = 8;
  localparam int SECT_W  = 3;
  localparam int REM_W   = 12;
  localparam int LEVEL_W = 20;
  localparam int PROD_W  = CH_W + LEVEL_W;
  localparam int SCALE_W = PROD_W + BYTE_W;
  localparam int Y_W     = 12;

  // The common denominator ONE*ONE*60<<HUE_FRAC_BITS is 2^24 * 15.
  localparam int Y_LSB       = 2 * CHANNEL_FRAC_BITS + HUE_FRAC_BITS + 2;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP15 = 13'd4370;

  localparam logic [CH_W-1:0]    CH_ONE      = CH_W'(1 << CHANNEL_FRAC_BITS);
  localparam logic [REM_W-1:0]   SECTOR_SPAN = REM_W'(60 << HUE_FRAC_BITS);
  localparam logic [HUE_W-1:0]   HUE_FULL    = HUE_W'(360 << HUE_FRAC_BITS);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  =
    LEVEL_W'((1 << CHANNEL_FRAC_BITS) * (60 << HUE_FRAC_BITS));

  localparam logic [SECT_W-1:0] SECTOR_0 = 3'd0;
  localparam logic [SECT_W-1:0] SECTOR_1 = 3'd1;
  localparam logic [SECT_W-1:0] SECTOR_2 = 3'd2;
  localparam logic [SECT_W-1:0] SECTOR_3 = 3'd3;
  localparam logic [SECT_W-1:0] SECTOR_4 = 3'd4;
  localparam logic [SECT_W-1:0] SECTOR_5 = 3'd5;

  typedef struct packed {
    logic [SECT_W-1:0] sector;
    logic [REM_W-1:0]  rem;
    logic [CH_W-1:0]   sat;
    logic [CH_W-1:0]   val;
  } sector_t;

  typedef struct packed {
    logic [CH_W-1:0]    val;
    logic [LEVEL_W-1:0] x_r;
    logic [LEVEL_W-1:0] x_g;
    logic [LEVEL_W-1:0] x_b;
  } level_t;

endpackage

// ----- sv/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Throughput is one pixel per clock; the six pipeline stages all advance
// together whenever the output register is empty or being read.
// Reset clears only the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // hue [14:0], saturation [23:15], brightness [32:24], zero fill [39:33]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [23:0] m_axis_tdata
);

  // The whole pipeline moves as one shift line. It advances when the output
  // register has no pixel or the pixel there is being taken this cycle, so a
  // stall simply freezes every stage and nothing is dropped or duplicated.
  logic en;

  logic    sec_valid;
  sector_t sec_data;
  logic    lvl_valid;
  level_t  lvl_data;

  // Valid bits for the three scaling stages, which carry no control of
  // their own.
  logic [2:0] scl_valid;

  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;

  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: input clamping, wrap of a full turn, sector split.
  hsv2rgb_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_axis_tvalid),
    .hue        (s_axis_tdata[14:0]),
    .saturation (s_axis_tdata[23:15]),
    .brightness (s_axis_tdata[32:24]),
    .out_valid  (sec_valid),
    .out_data   (sec_data)
  );

  // Stages 2 and 3: s*f products, then p/q/t levels routed by sector. Zero
  // saturation needs no special path: every level then equals the value.
  hsv2rgb_level u_level (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sec_valid),
    .in_data   (sec_data),
    .out_valid (lvl_valid),
    .out_data  (lvl_data)
  );

  // Stages 4 to 6: one scaling unit per channel. The last register of each
  // is the output register.
  hsv2rgb_scale u_scale_r (
    .clk   (clk),
    .en    (en),
    .val   (lvl_data.val),
    .level (lvl_data.x_r),
    .chan  (red)
  );

  hsv2rgb_scale u_scale_g (
    .clk   (clk),
    .en    (en),
    .val   (lvl_data.val),
    .level (lvl_data.x_g),
    .chan  (green)
  );

  hsv2rgb_scale u_scale_b (
    .clk   (clk),
    .en    (en),
    .val   (lvl_data.val),
    .level (lvl_data.x_b),
    .chan  (blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_valid <= '0;
    end else if (en) begin
      scl_valid <= {scl_valid[1:0], lvl_valid};
    end
  end

  assign m_axis_tvalid = scl_valid[2];
  assign m_axis_tdata  = {blue, green, red};

  // The sector split never yields a code past the last sector.
  a_sector_range : assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> (sec_data.sector <= SECTOR_5))
    else $error("sector code out of range");

  // The remainder always lies inside one sector span.
  a_rem_range : assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> (sec_data.rem < SECTOR_SPAN))
    else $error("hue remainder not below sector span");

  // An accepted request is on the output once the pipeline has advanced it through every stage.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) ##1 en ##1 en ##1 en ##1 en ##1 en
      |=> m_axis_tvalid)
    else $error("accepted request did not reach the output in six stages");

endmodule

// ----- sv/hsv2rgb_sector.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// First pipeline stage: clamps saturation and brightness, wraps hue at or
// above a full turn to zero, and splits hue into a sector and the remainder inside that sector.
// ----------------------------------------------------------------------------
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [HUE_W-1:0] hue,
  input  logic [CH_W-1:0]  saturation,
  input  logic [CH_W-1:0]  brightness,
  output logic             out_valid,
  output sector_t          out_data
);

  logic [HUE_W-1:0] hue_c;
  logic [HUE_W-1:0] base;
  logic [HUE_W-1:0] diff;
  sector_t          data_next;

  always_comb begin
    // Hue at or above a full turn wraps to zero.
    hue_c = (hue >= HUE_FULL) ? '0 : hue;
    priority if (hue_c < HUE_W'(SECTOR_SPAN)) begin
      data_next.sector = SECTOR_0;
      base             = '0;
    end else if (hue_c < HUE_W'(2 * SECTOR_SPAN)) begin
      data_next.sector = SECTOR_1;
      base             = HUE_W'(SECTOR_SPAN);
    end else if (hue_c < HUE_W'(3 * SECTOR_SPAN)) begin
      data_next.sector = SECTOR_2;
      base             = HUE_W'(2 * SECTOR_SPAN);
    end else if (hue_c < HUE_W'(4 * SECTOR_SPAN)) begin
      data_next.sector = SECTOR_3;
      base             = HUE_W'(3 * SECTOR_SPAN);
    end else if (hue_c < HUE_W'(5 * SECTOR_SPAN)) begin
      data_next.sector = SECTOR_4;
      base             = HUE_W'(4 * SECTOR_SPAN);
    end else begin
      data_next.sector = SECTOR_5;
      base             = HUE_W'(5 * SECTOR_SPAN);
    end
    diff           = hue_c - base;
    data_next.rem  = diff[REM_W-1:0];
    data_next.sat  = (saturation > CH_ONE) ? CH_ONE : saturation;
    data_next.val  = (brightness > CH_ONE) ? CH_ONE : brightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- sv/hsv2rgb_level.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_level
// Two stages: forms the s*f products, then the p, q and t levels over the
// common denominator, and routes them to red, green and blue by sector.
// ----------------------------------------------------------------------------
module hsv2rgb_level
  import hsv2rgb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  sector_t in_data,
  output logic    out_valid,
  output level_t  out_data
);

  localparam int SR_W = CH_W + REM_W;

  // Product stage registers.
  logic                valid_a;
  logic [SECT_W-1:0]   sector_a;
  logic [CH_W-1:0]     sat_a;
  logic [CH_W-1:0]     val_a;
  logic [LEVEL_W-1:0]  sq_a;
  logic [LEVEL_W-1:0]  st_a;

  logic [REM_W-1:0]    rem_inv;
  logic [SR_W-1:0]     sq_full;
  logic [SR_W-1:0]     st_full;

  logic [CH_W-1:0]     one_minus_s;
  logic [LEVEL_W-1:0]  xp;
  logic [LEVEL_W-1:0]  xq;
  logic [LEVEL_W-1:0]  xt;
  level_t              data_next;

  always_comb begin
    rem_inv = SECTOR_SPAN - in_data.rem;
    sq_full = SR_W'(in_data.sat) * SR_W'(in_data.rem);
    st_full = SR_W'(in_data.sat) * SR_W'(rem_inv);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector_a <= in_data.sector;
      sat_a    <= in_data.sat;
      val_a    <= in_data.val;
      sq_a     <= sq_full[LEVEL_W-1:0];
      st_a     <= st_full[LEVEL_W-1:0];
    end
  end

  always_comb begin
    one_minus_s   = CH_ONE - sat_a;
    xp            = LEVEL_W'(one_minus_s) * LEVEL_W'(SECTOR_SPAN);
    xq            = LEVEL_FULL - sq_a;
    xt            = LEVEL_FULL - st_a;
    data_next.val = val_a;
    unique case (sector_a)
      SECTOR_0: begin
        data_next.x_r = LEVEL_FULL;
        data_next.x_g = xt;
        data_next.x_b = xp;
      end
      SECTOR_1: begin
        data_next.x_r = xq;
        data_next.x_g = LEVEL_FULL;
        data_next.x_b = xp;
      end
      SECTOR_2: begin
        data_next.x_r = xp;
        data_next.x_g = LEVEL_FULL;
        data_next.x_b = xt;
      end
      SECTOR_3: begin
        data_next.x_r = xp;
        data_next.x_g = xq;
        data_next.x_b = LEVEL_FULL;
      end
      SECTOR_4: begin
        data_next.x_r = xt;
        data_next.x_g = xp;
        data_next.x_b = LEVEL_FULL;
      end
      default: begin
        data_next.x_r = LEVEL_FULL;
        data_next.x_g = xp;
        data_next.x_b = xq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in_valid;
      out_valid <= valid_a;
    end
  end

endmodule

// ----- sv/hsv2rgb_scale.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Three stages for one channel: multiplies by the value, by 255, and divides
// by the common denominator (a shift and a reciprocal multiply by 1/15).
// ----------------------------------------------------------------------------
module hsv2rgb_scale
  import hsv2rgb_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [CH_W-1:0]    val,
  input  logic [LEVEL_W-1:0] level,
  output logic [BYTE_W-1:0]  chan
);

  localparam int Q_W = Y_W + RECIP_W;

  logic [PROD_W-1:0]  prod;
  logic [SCALE_W-1:0] scaled;
  logic [Y_W-1:0]     y;
  logic [Q_W-1:0]     quot;

  // 255 * m is formed as 256 * m - m.
  assign scaled = {prod, BYTE_W'(0)} - SCALE_W'(prod);
  assign quot   = Q_W'(y) * Q_W'(RECIP15);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(val) * PROD_W'(level);
      y    <= scaled[Y_LSB +: Y_W];
      chan <= quot[RECIP_SHIFT +: BYTE_W];
    end
  end

endmodule
